@@ sv/ntcm_pkg.sv @@
// ---------------------------------------------------------------------------
// ntcm_pkg: shared types and constants of the NTC over-temperature monitor
// Holds the item types, the register indexes and the microcode table.
// ---------------------------------------------------------------------------
package ntcm_pkg;

	localparam int NTC_SLOTS = 4;
	localparam int SMP_W     = 16;
	localparam int SUM_W     = 24;
	localparam int CNT_W     = 8;
	localparam int REG_IDX_W = 3;
	localparam int PC_W      = 4;

	localparam logic [SMP_W-1:0] AVG_RESET = 16'd890;
	localparam logic [SMP_W-1:0] CNT_MAX   = 16'hFFFF;

	// Register indexes on the configuration channel.
	localparam logic [REG_IDX_W-1:0] R_AVG_COUNT  = 3'd0;
	localparam logic [REG_IDX_W-1:0] R_OT_SET     = 3'd1;
	localparam logic [REG_IDX_W-1:0] R_OT_CLEAR   = 3'd2;
	localparam logic [REG_IDX_W-1:0] R_OT_DELAY   = 3'd3;
	localparam logic [REG_IDX_W-1:0] R_WARN_SET   = 3'd4;
	localparam logic [REG_IDX_W-1:0] R_WARN_CLEAR = 3'd5;
	localparam logic [REG_IDX_W-1:0] R_WARN_DELAY = 3'd6;
	localparam logic [REG_IDX_W-1:0] R_OT_DISABLE = 3'd7;

	// Input opcodes.
	localparam logic OP_SAMPLE  = 1'b0;
	localparam logic OP_MONITOR = 1'b1;

	// Microprogram steps.
	localparam logic [PC_W-1:0] S_IDLE = 4'd0;
	localparam logic [PC_W-1:0] S_SAMP = 4'd1;
	localparam logic [PC_W-1:0] S_CHK  = 4'd2;
	localparam logic [PC_W-1:0] S_DIV  = 4'd3;
	localparam logic [PC_W-1:0] S_DIVR = 4'd4;
	localparam logic [PC_W-1:0] S_WB   = 4'd5;
	localparam logic [PC_W-1:0] S_END  = 4'd6;
	localparam logic [PC_W-1:0] S_MON  = 4'd7;
	localparam logic [PC_W-1:0] S_PSU  = 4'd8;
	localparam logic [PC_W-1:0] S_OUT  = 4'd9;

	// Sequencer branch conditions.
	localparam logic [2:0] C_NEXT  = 3'd0; // fall through
	localparam logic [2:0] C_JMP   = 3'd1; // always jump
	localparam logic [2:0] C_IN    = 3'd2; // wait for an input beat, jump on monitor
	localparam logic [2:0] C_OPEN  = 3'd3; // jump if the block is still open
	localparam logic [2:0] C_BUSY  = 3'd4; // jump while the divider runs
	localparam logic [2:0] C_MORE  = 3'd5; // jump if channels remain
	localparam logic [2:0] C_OUTW  = 3'd6; // wait for the output register, then jump

	typedef struct packed {
		logic             opcode;
		logic [SMP_W-1:0] sample_0;
		logic [SMP_W-1:0] sample_1;
		logic [SMP_W-1:0] sample_2;
		logic [SMP_W-1:0] sample_3;
	} in_item_t;

	typedef struct packed {
		logic [SMP_W-1:0]     avg_0;
		logic [SMP_W-1:0]     avg_1;
		logic [SMP_W-1:0]     avg_2;
		logic [SMP_W-1:0]     avg_3;
		logic                 avg_valid;
		logic [NTC_SLOTS-1:0] ot_flags;
		logic [NTC_SLOTS-1:0] warn_flags;
		logic                 psu_ot;
	} out_item_t;

	typedef struct packed {
		logic [PC_W-1:0] target;
		logic [2:0]      cond;
		logic            in_rdy;
		logic            acc;
		logic            div_start;
		logic            wb;
		logic            fin;
		logic            mon;
		logic            psu;
		logic            out_ld;
	} ctrl_t;

	typedef struct packed {
		logic in_beat;
		logic opcode;
		logic blk_open;
		logic div_busy;
		logic more_ch;
		logic out_busy;
	} seq_cond_t;

	// Microcode table: one control word per step.
	function automatic ctrl_t ucode_rom(input logic [PC_W-1:0] pc);
		ctrl_t cw;
		cw = '0;
		unique case (pc)
			S_IDLE: begin
				cw.in_rdy = 1'b1;
				cw.cond   = C_IN;
				cw.target = S_MON;
			end
			S_SAMP: begin
				cw.acc  = 1'b1;
				cw.cond = C_NEXT;
			end
			S_CHK: begin
				cw.cond   = C_OPEN;
				cw.target = S_OUT;
			end
			S_DIV: begin
				cw.div_start = 1'b1;
				cw.cond      = C_NEXT;
			end
			S_DIVR: begin
				cw.cond   = C_BUSY;
				cw.target = S_DIVR;
			end
			S_WB: begin
				cw.wb     = 1'b1;
				cw.cond   = C_MORE;
				cw.target = S_DIV;
			end
			S_END: begin
				cw.fin    = 1'b1;
				cw.cond   = C_JMP;
				cw.target = S_OUT;
			end
			S_MON: begin
				cw.mon  = 1'b1;
				cw.cond = C_NEXT;
			end
			S_PSU: begin
				cw.psu  = 1'b1;
				cw.cond = C_NEXT;
			end
			S_OUT: begin
				cw.out_ld = 1'b1;
				cw.cond   = C_OUTW;
				cw.target = S_IDLE;
			end
			default: begin
				cw.cond   = C_JMP;
				cw.target = S_IDLE;
			end
		endcase
		return cw;
	endfunction

endpackage

@@ sv/ntcm_if.sv @@
// ---------------------------------------------------------------------------
// ntcm_if: channel interfaces of the NTC over-temperature monitor
// Input item channel, result channel and configuration write channel.
// ---------------------------------------------------------------------------
interface ntcm_in_if;
	import ntcm_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t item;
	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

interface ntcm_out_if;
	import ntcm_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t item;
	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

interface ntcm_cfg_if;
	import ntcm_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [REG_IDX_W-1:0] index;
	logic [SMP_W-1:0]     wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

@@ sv/ntcm_seq.sv @@
// ---------------------------------------------------------------------------
// ntcm_seq: microcode sequencer
// Step counter, control store lookup and conditional branching.
// ---------------------------------------------------------------------------
module ntcm_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ntcm_pkg::seq_cond_t           cond_in,
	output ntcm_pkg::ctrl_t               cw,
	output logic [ntcm_pkg::PC_W-1:0]     pc
);
	import ntcm_pkg::*;

	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_nxt;
	logic [PC_W-1:0] pc_inc;

	assign cw     = ucode_rom(pc_q);
	assign pc     = pc_q;
	assign pc_inc = pc_q + PC_W'(1);

	always_comb begin
		unique case (cw.cond)
			C_NEXT: pc_nxt = pc_inc;
			C_JMP:  pc_nxt = cw.target;
			C_IN:   pc_nxt = !cond_in.in_beat ? pc_q :
			                 (cond_in.opcode == OP_MONITOR) ? cw.target : pc_inc;
			C_OPEN: pc_nxt = cond_in.blk_open ? cw.target : pc_inc;
			C_BUSY: pc_nxt = cond_in.div_busy ? cw.target : pc_inc;
			C_MORE: pc_nxt = cond_in.more_ch ? cw.target : pc_inc;
			C_OUTW: pc_nxt = cond_in.out_busy ? pc_q : cw.target;
			default: pc_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_IDLE;
		end else begin
			pc_q <= pc_nxt;
		end
	end

endmodule

@@ sv/ntcm_div.sv @@
// ---------------------------------------------------------------------------
// ntcm_div: serial restoring divider
// Divides a channel sum by the sample count, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module ntcm_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [ntcm_pkg::SUM_W-1:0] dividend,
	input  logic [ntcm_pkg::CNT_W-1:0] divisor,
	output logic                      busy,
	output logic [ntcm_pkg::SUM_W-1:0] quotient
);
	import ntcm_pkg::*;

	localparam int BIT_W = $clog2(SUM_W + 1);

	logic [BIT_W-1:0] bits_q;
	logic [SUM_W-1:0] dvd_q;
	logic [CNT_W-1:0] rem_q;
	logic [CNT_W:0]   rem_sh;
	logic [CNT_W:0]   rem_diff;
	logic             ge;

	assign rem_sh   = {rem_q, dvd_q[SUM_W-1]};
	assign rem_diff = rem_sh - {1'b0, divisor};
	assign ge       = rem_sh >= {1'b0, divisor};
	assign busy     = bits_q != '0;
	assign quotient = dvd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q <= '0;
		end else if (start) begin
			bits_q <= BIT_W'(SUM_W);
		end else if (busy) begin
			bits_q <= bits_q - BIT_W'(1);
		end
	end

	// The dividend register fills with quotient bits from the right.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy) begin
			dvd_q <= {dvd_q[SUM_W-2:0], ge};
			rem_q <= ge ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
		end
	end

endmodule

@@ sv/ntcm_det.sv @@
// ---------------------------------------------------------------------------
// ntcm_det: debounced hysteresis detector
// One delay counter and one flag for one channel and one threshold pair.
// ---------------------------------------------------------------------------
module ntcm_det (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic [ntcm_pkg::SMP_W-1:0] avg,
	input  logic [ntcm_pkg::SMP_W-1:0] set_lvl,
	input  logic [ntcm_pkg::SMP_W-1:0] clr_lvl,
	input  logic [ntcm_pkg::SMP_W-1:0] dly,
	output logic                      flag
);
	import ntcm_pkg::*;

	logic [SMP_W-1:0] cnt_q;
	logic             flag_q;

	assign flag = flag_q;

	// Below the set level the counter climbs and the flag sets once it
	// passes the delay; above the clear level it falls and the flag clears
	// at zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			flag_q <= 1'b0;
		end else if (en) begin
			if (avg < set_lvl) begin
				if (cnt_q > dly) begin
					flag_q <= 1'b1;
				end else if (cnt_q != CNT_MAX) begin
					cnt_q <= cnt_q + SMP_W'(1);
				end
			end else if (avg > clr_lvl) begin
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - SMP_W'(1);
				end else begin
					flag_q <= 1'b0;
				end
			end
		end
	end

endmodule

@@ sv/ntc_average_overtemp_monitor.sv @@
// ---------------------------------------------------------------------------
// ntc_average_overtemp_monitor: NTC block averager and over-temperature monitor
// Averages per-channel resistance readings and debounces OT and warning flags.
// ---------------------------------------------------------------------------
// Usage. Items arrive on in_ch. A sample item (opcode 0) adds each reading to
// its channel sum; when the block length is reached every sum is divided by
// the sample count and avg_valid is raised in that item's result. A monitor
// item (opcode 1) runs the OT and warning detectors on the current averages
// and refreshes psu_ot. Each item produces exactly one result beat on out_ch.
// Registers are written on cfg by index; the user must write them only while
// the block is idle, as the block does not enforce it; cfg is always ready.
// Timing. A microcoded sequencer handles one item at a time and takes the
// next input beat only once the result of the last item is loaded. A sample
// item that does not close a block passes the sample, check and output
// steps; a monitor item passes the monitor, PSU and output steps. A sample
// item that closes a block runs, per channel, a start step for the shared
// serial divider, a wait step that ends once the divider is no longer busy,
// and a write-back step; then it runs an end step and the output step.
// Reset clears the sums, counters and flags, loads 890 into every average and
// restores the register defaults. When the receiver stalls, the result sits
// in the output register and the next input beat is still taken; the
// sequencer waits at its output step only if that register is still full.
// ---------------------------------------------------------------------------
module ntc_average_overtemp_monitor #(
	parameter int CHANNELS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	ntcm_in_if.sink     in_ch,
	ntcm_out_if.source  out_ch,
	ntcm_cfg_if.sink    cfg
);
	import ntcm_pkg::*;

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// Configuration registers.
	logic [CNT_W-1:0] avg_count_q;
	logic [SMP_W-1:0] ot_set_q;
	logic [SMP_W-1:0] ot_clear_q;
	logic [SMP_W-1:0] ot_delay_q;
	logic [SMP_W-1:0] warn_set_q;
	logic [SMP_W-1:0] warn_clear_q;
	logic [SMP_W-1:0] warn_delay_q;
	logic             ot_disable_q;

	// Datapath state.
	logic [SUM_W-1:0] sum_q [CHANNELS];
	logic [SMP_W-1:0] avg_q [CHANNELS];
	logic [CNT_W-1:0] count_q;
	logic [CH_W-1:0]  ch_q;
	logic             valid_q;
	logic             psu_q;
	in_item_t         in_q;

	// Output register.
	out_item_t        out_q;
	logic             out_valid_q;

	ctrl_t            cw;
	seq_cond_t        cond;
	logic [PC_W-1:0]  pc;
	logic             in_beat;
	logic             cfg_beat;
	logic             out_busy;
	logic [CNT_W-1:0] limit;
	logic             blk_done;
	logic             div_busy;
	logic [SUM_W-1:0] quot;
	logic [SMP_W-1:0] quot_sat;
	logic [CHANNELS-1:0] ot_vec;
	logic [CHANNELS-1:0] warn_vec;
	logic [SMP_W-1:0] samp [NTC_SLOTS];
	logic [SMP_W-1:0] avg_slot [NTC_SLOTS];
	logic [NTC_SLOTS-1:0] ot_slot;
	logic [NTC_SLOTS-1:0] warn_slot;

	assign in_ch.ready = cw.in_rdy;
	assign in_beat     = in_ch.valid && in_ch.ready;
	assign cfg.ready   = 1'b1;
	assign cfg_beat    = cfg.valid && cfg.ready;
	assign out_busy    = out_valid_q && !out_ch.ready;

	// A zero block length closes a block on every sample.
	assign limit    = (avg_count_q == '0) ? CNT_W'(1) : avg_count_q;
	assign blk_done = (count_q >= limit) && (count_q != '0);

	assign cond.in_beat  = in_beat;
	assign cond.opcode   = in_ch.item.opcode;
	assign cond.blk_open = !blk_done;
	assign cond.div_busy = div_busy;
	assign cond.more_ch  = ch_q != CH_W'(CHANNELS - 1);
	assign cond.out_busy = out_busy;

	ntcm_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.cond_in (cond),
		.cw      (cw),
		.pc      (pc)
	);

	ntcm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cw.div_start),
		.dividend (sum_q[ch_q]),
		.divisor  (count_q),
		.busy     (div_busy),
		.quotient (quot)
	);

	// The quotient never exceeds 16 bits for real data; clamp all the same.
	assign quot_sat = (quot[SUM_W-1:SMP_W] != '0) ? CNT_MAX : quot[SMP_W-1:0];

	assign samp[0] = in_q.sample_0;
	assign samp[1] = in_q.sample_1;
	assign samp[2] = in_q.sample_2;
	assign samp[3] = in_q.sample_3;

	// One OT and one warning detector per channel, all stepped together.
	for (genvar i = 0; i < CHANNELS; i++) begin : g_det
		ntcm_det u_ot (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (cw.mon),
			.avg     (avg_q[i]),
			.set_lvl (ot_set_q),
			.clr_lvl (ot_clear_q),
			.dly     (ot_delay_q),
			.flag    (ot_vec[i])
		);
		ntcm_det u_warn (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (cw.mon),
			.avg     (avg_q[i]),
			.set_lvl (warn_set_q),
			.clr_lvl (warn_clear_q),
			.dly     (warn_delay_q),
			.flag    (warn_vec[i])
		);
	end

	// Slots beyond the configured channel count report zero.
	for (genvar j = 0; j < NTC_SLOTS; j++) begin : g_slot
		if (j < CHANNELS) begin : g_used
			assign avg_slot[j]  = avg_q[j];
			assign ot_slot[j]   = ot_vec[j];
			assign warn_slot[j] = warn_vec[j];
		end else begin : g_unused
			assign avg_slot[j]  = '0;
			assign ot_slot[j]   = 1'b0;
			assign warn_slot[j] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_count_q  <= CNT_W'(16);
			ot_set_q     <= '0;
			ot_clear_q   <= CNT_MAX;
			ot_delay_q   <= '0;
			warn_set_q   <= '0;
			warn_clear_q <= CNT_MAX;
			warn_delay_q <= '0;
			ot_disable_q <= 1'b0;
		end else if (cfg_beat) begin
			unique case (cfg.index)
				R_AVG_COUNT:  avg_count_q  <= cfg.wdata[CNT_W-1:0];
				R_OT_SET:     ot_set_q     <= cfg.wdata;
				R_OT_CLEAR:   ot_clear_q   <= cfg.wdata;
				R_OT_DELAY:   ot_delay_q   <= cfg.wdata;
				R_WARN_SET:   warn_set_q   <= cfg.wdata;
				R_WARN_CLEAR: warn_clear_q <= cfg.wdata;
				R_WARN_DELAY: warn_delay_q <= cfg.wdata;
				R_OT_DISABLE: ot_disable_q <= cfg.wdata[0];
				default: ;
			endcase
		end
	end

	// Input beat capture.
	always_ff @(posedge clk) begin
		if (in_beat) begin
			in_q <= in_ch.item;
		end
	end

	// Sums, averages and block bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < CHANNELS; k++) begin
				sum_q[k] <= '0;
				avg_q[k] <= AVG_RESET;
			end
			count_q <= '0;
			ch_q    <= '0;
			valid_q <= 1'b0;
			psu_q   <= 1'b0;
		end else begin
			if (in_beat) begin
				valid_q <= 1'b0;
			end
			if (cw.acc) begin
				for (int k = 0; k < CHANNELS; k++) begin
					sum_q[k] <= sum_q[k] + SUM_W'(samp[k]);
				end
				count_q <= count_q + CNT_W'(1);
				ch_q    <= '0;
			end
			if (cw.wb) begin
				avg_q[ch_q] <= quot_sat;
				sum_q[ch_q] <= '0;
				ch_q        <= ch_q + CH_W'(1);
			end
			if (cw.fin) begin
				count_q <= '0;
				valid_q <= 1'b1;
			end
			if (cw.psu) begin
				psu_q <= (ot_vec != '0) && !ot_disable_q;
			end
		end
	end

	// Output register: loaded at the output step once it is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cw.out_ld && !out_busy) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cw.out_ld && !out_busy) begin
			out_q.avg_0      <= avg_slot[0];
			out_q.avg_1      <= avg_slot[1];
			out_q.avg_2      <= avg_slot[2];
			out_q.avg_3      <= avg_slot[3];
			out_q.avg_valid  <= valid_q;
			out_q.ot_flags   <= ot_slot;
			out_q.warn_flags <= warn_slot;
			out_q.psu_ot     <= psu_q;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.item  = out_q;

	// The divider only runs while the sequencer waits on it.
	a_div_in_loop: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> pc == S_DIVR)
		else $error("divider busy outside the divide loop");

	// A division never starts with a zero sample count.
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cw.div_start |-> count_q != '0)
		else $error("division started with zero count");

	// An input beat dispatches to the sample or the monitor routine.
	a_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> (pc == S_SAMP || pc == S_MON))
		else $error("input beat did not dispatch");

	// Flags and psu_ot only change on a monitor item's steps.
	a_flags_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!cw.mon && !cw.psu) |=> ($stable(ot_vec) && $stable(psu_q)))
		else $error("flags changed outside a monitor item");

endmodule

@@ bench/ntc_average_overtemp_monitor_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ntc_average_overtemp_monitor_tb: self-checking bench of the NTC monitor
// Drives sample and monitor items with random gaps, programs the registers
// between phases and compares every result beat with an in-bench predictor.
// ---------------------------------------------------------------------------
module ntc_average_overtemp_monitor_tb;
	import ntcm_pkg::*;

	localparam int CHANNELS = 4;

	// Predictor of the averager and both debounced detectors. It keeps its own
	// copy of the registers and of the block state, and queues one expected
	// readout per accepted input beat.
	class ntc_monitor_model;
		logic [7:0]  avg_count;
		logic [15:0] ot_set, ot_clear, ot_delay;
		logic [15:0] warn_set, warn_clear, warn_delay;
		logic        ot_disable;

		logic [23:0] sums [NTC_SLOTS];
		logic [15:0] avgs [NTC_SLOTS];
		logic [7:0]  tick_count;
		logic [15:0] ot_cnt [NTC_SLOTS];
		logic [15:0] warn_cnt [NTC_SLOTS];
		logic [3:0]  ot_bits, warn_bits;
		logic        psu_bit;

		out_item_t   readouts [$];
		int          errors;

		function new();
			avg_count  = 8'd16;
			ot_set     = 16'd0;
			ot_clear   = 16'hFFFF;
			ot_delay   = 16'd0;
			warn_set   = 16'd0;
			warn_clear = 16'hFFFF;
			warn_delay = 16'd0;
			ot_disable = 1'b0;
			for (int i = 0; i < NTC_SLOTS; i++) begin
				sums[i]     = '0;
				avgs[i]     = AVG_RESET;
				ot_cnt[i]   = '0;
				warn_cnt[i] = '0;
			end
			tick_count = '0;
			ot_bits    = '0;
			warn_bits  = '0;
			psu_bit    = 1'b0;
			errors     = 0;
		endfunction

		function void write_reg(logic [REG_IDX_W-1:0] idx, logic [15:0] val);
			case (idx)
				R_AVG_COUNT:  avg_count  = val[7:0];
				R_OT_SET:     ot_set     = val;
				R_OT_CLEAR:   ot_clear   = val;
				R_OT_DELAY:   ot_delay   = val;
				R_WARN_SET:   warn_set   = val;
				R_WARN_CLEAR: warn_clear = val;
				R_WARN_DELAY: warn_delay = val;
				R_OT_DISABLE: ot_disable = val[0];
				default: ;
			endcase
		endfunction

		// One hysteresis step: count up while below the set level, count down
		// while above the clear level, and move the flag at either end.
		function void debounce(input logic [15:0] avg, input logic [15:0] set_lvl,
				input logic [15:0] clr_lvl, input logic [15:0] dly,
				inout logic [15:0] cnt, inout logic flag);
			if (avg < set_lvl) begin
				if (cnt > dly)
					flag = 1'b1;
				else if (cnt != 16'hFFFF)
					cnt = cnt + 16'd1;
			end else if (avg > clr_lvl) begin
				if (cnt != 16'd0)
					cnt = cnt - 16'd1;
				else
					flag = 1'b0;
			end
		endfunction

		function void take_item(in_item_t it);
			logic [15:0] rd [NTC_SLOTS];
			logic [7:0]  limit;
			logic [23:0] q;
			logic        done;
			out_item_t   r;
			rd[0] = it.sample_0;
			rd[1] = it.sample_1;
			rd[2] = it.sample_2;
			rd[3] = it.sample_3;
			done  = 1'b0;
			if (it.opcode == OP_SAMPLE) begin
				limit = (avg_count == 8'd0) ? 8'd1 : avg_count;
				for (int i = 0; i < CHANNELS; i++)
					sums[i] = sums[i] + {8'd0, rd[i]};
				tick_count = tick_count + 8'd1;
				if (tick_count >= limit && tick_count != 8'd0) begin
					for (int i = 0; i < CHANNELS; i++) begin
						q       = sums[i] / {16'd0, tick_count};
						avgs[i] = (q > 24'h00FFFF) ? 16'hFFFF : q[15:0];
						sums[i] = '0;
					end
					tick_count = '0;
					done       = 1'b1;
				end
			end else begin
				for (int i = 0; i < CHANNELS; i++) begin
					debounce(avgs[i], ot_set, ot_clear, ot_delay, ot_cnt[i], ot_bits[i]);
					debounce(avgs[i], warn_set, warn_clear, warn_delay, warn_cnt[i],
						warn_bits[i]);
				end
				psu_bit = (ot_bits != 4'd0) && !ot_disable;
			end
			r.avg_0      = (CHANNELS > 0) ? avgs[0] : 16'd0;
			r.avg_1      = (CHANNELS > 1) ? avgs[1] : 16'd0;
			r.avg_2      = (CHANNELS > 2) ? avgs[2] : 16'd0;
			r.avg_3      = (CHANNELS > 3) ? avgs[3] : 16'd0;
			r.avg_valid  = done;
			r.ot_flags   = ot_bits;
			r.warn_flags = warn_bits;
			r.psu_ot     = psu_bit;
			readouts.push_back(r);
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (readouts.size() == 0) begin
				$display("%0t: unexpected result beat, expected none, actual %h", $time, got);
				errors++;
				return;
			end
			want = readouts.pop_front();
			compare_field("avg_0", want.avg_0, got.avg_0);
			compare_field("avg_1", want.avg_1, got.avg_1);
			compare_field("avg_2", want.avg_2, got.avg_2);
			compare_field("avg_3", want.avg_3, got.avg_3);
			compare_field("avg_valid", {15'd0, want.avg_valid}, {15'd0, got.avg_valid});
			compare_field("ot_flags", {12'd0, want.ot_flags}, {12'd0, got.ot_flags});
			compare_field("warn_flags", {12'd0, want.warn_flags}, {12'd0, got.warn_flags});
			compare_field("psu_ot", {15'd0, want.psu_ot}, {15'd0, got.psu_ot});
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	ntcm_in_if  in_ch ();
	ntcm_out_if out_ch ();
	ntcm_cfg_if cfg ();

	ntc_average_overtemp_monitor #(
		.CHANNELS(CHANNELS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg(cfg)
	);

	ntc_monitor_model sb = new();

	// When calm is set both sides run without gaps for the whole phase.
	bit calm;

	// Levels of the current phase that the random readings cluster around.
	int lvl_ot, lvl_warn;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int draw_gap();
		return calm ? 0 : int'($urandom_range(0, 3));
	endfunction

	// A reading either fully random or near one of the phase's set levels, so
	// that the averages straddle the thresholds often.
	function automatic logic [15:0] pick_reading();
		int v;
		case ($urandom_range(0, 2))
			0: v = int'($urandom_range(0, 65535));
			1: v = lvl_ot + int'($urandom_range(0, 4000)) - 2000;
			default: v = lvl_warn + int'($urandom_range(0, 4000)) - 2000;
		endcase
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return v[15:0];
	endfunction

	// Sends one item. After its beat valid stays high with the old payload, so
	// the caller either sends again in the same step or calls in_idle first.
	task automatic send_item(in_item_t it);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.item  <= it;
		do
			@(posedge clk);
		while (!in_ch.ready);
		sb.take_item(it);
	endtask

	task automatic send_fields(logic op, logic [15:0] a, logic [15:0] b,
			logic [15:0] c, logic [15:0] d);
		in_item_t it;
		it.opcode   = op;
		it.sample_0 = a;
		it.sample_1 = b;
		it.sample_2 = c;
		it.sample_3 = d;
		send_item(it);
	endtask

	task automatic in_idle();
		in_ch.valid <= 1'b0;
	endtask

	// Waits until every expected readout has come back, plus a short margin.
	task automatic drain_results();
		while (sb.readouts.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// One register write; the spacer cycle keeps valid from being lowered and
	// raised in the same step on back-to-back writes.
	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [15:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.wdata <= val;
		do
			@(posedge clk);
		while (!cfg.ready);
		sb.write_reg(idx, val);
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic program_regs(logic [7:0] n, logic [15:0] ots, logic [15:0] otc,
			logic [15:0] otd, logic [15:0] ws, logic [15:0] wc, logic [15:0] wd,
			logic dis);
		write_reg(R_AVG_COUNT, {8'd0, n});
		write_reg(R_OT_SET, ots);
		write_reg(R_OT_CLEAR, otc);
		write_reg(R_OT_DELAY, otd);
		write_reg(R_WARN_SET, ws);
		write_reg(R_WARN_CLEAR, wc);
		write_reg(R_WARN_DELAY, wd);
		write_reg(R_OT_DISABLE, {15'd0, dis});
	endtask

	// Result side: check every accepted beat, then hold ready low for a drawn
	// number of cycles. This process alone drives out_ch.ready.
	initial begin
		int stall_left;
		stall_left   = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready) begin
				sb.check_result(out_ch.item);
				stall_left = draw_gap();
			end else if (stall_left > 0) begin
				stall_left--;
			end
			out_ch.ready <= arst_n && (stall_left == 0);
		end
	end

	// Stimulus: directed special cases first, then randomized phases.
	initial begin
		logic [7:0]  n;
		logic [15:0] ots, otc, otd, ws, wc, wd;
		logic        dis;
		int          pause_at;
		in_item_t    it;

		arst_n      = 1'b0;
		calm        = 1'b0;
		lvl_ot      = 1000;
		lvl_warn    = 3000;
		in_ch.valid = 1'b0;
		in_ch.item  = '0;
		cfg.valid   = 1'b0;
		cfg.index   = R_AVG_COUNT;
		cfg.wdata   = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: a block of 16, and levels that never trigger.
		send_fields(OP_MONITOR, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_fields(OP_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_fields(OP_SAMPLE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_fields(OP_SAMPLE, 16'h5555, 16'hAAAA, 16'h0F0F, 16'hF0F0);
		send_fields(OP_MONITOR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		in_idle();
		drain_results();

		// Zero block length: every sample beat closes a block. The OT flag sets
		// on the second low monitor tick and the warning on the fourth.
		program_regs(8'd0, 16'd1000, 16'd2000, 16'd0, 16'd3000, 16'd4000, 16'd2, 1'b0);
		send_fields(OP_SAMPLE, 16'd0, 16'd0, 16'd0, 16'd0);
		repeat (4) send_fields(OP_MONITOR, 16'd0, 16'd0, 16'd0, 16'd0);
		send_fields(OP_SAMPLE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		repeat (4) send_fields(OP_MONITOR, 16'd0, 16'd0, 16'd0, 16'd0);
		send_fields(OP_SAMPLE, 16'd500, 16'd1500, 16'd3500, 16'hFFFF);
		repeat (3) send_fields(OP_MONITOR, 16'd0, 16'd0, 16'd0, 16'd0);
		in_idle();
		drain_results();

		// Block length lowered mid-block: five beats summed at a length of
		// eight, then the length drops to three and the next beat divides by
		// six. The combined flag stays low while disabled, then follows.
		program_regs(8'd8, 16'd1000, 16'd2000, 16'd0, 16'd3000, 16'd4000, 16'd2, 1'b1);
		send_fields(OP_SAMPLE, 16'd100, 16'd2500, 16'd4100, 16'd60000);
		send_fields(OP_SAMPLE, 16'd200, 16'd2600, 16'd4200, 16'd61000);
		send_fields(OP_SAMPLE, 16'd300, 16'd2700, 16'd4300, 16'd62000);
		send_fields(OP_SAMPLE, 16'd400, 16'd2800, 16'd4400, 16'd63000);
		send_fields(OP_SAMPLE, 16'd500, 16'd2900, 16'd4500, 16'd64000);
		in_idle();
		drain_results();
		write_reg(R_AVG_COUNT, 16'd3);
		send_fields(OP_SAMPLE, 16'd600, 16'd3000, 16'd4600, 16'd65000);
		repeat (2) send_fields(OP_MONITOR, 16'd0, 16'd0, 16'd0, 16'd0);
		in_idle();
		drain_results();
		write_reg(R_OT_DISABLE, 16'd0);
		send_fields(OP_MONITOR, 16'd0, 16'd0, 16'd0, 16'd0);
		in_idle();
		drain_results();

		// Widest block: 255 full-scale readings must fit the 24-bit sums.
		program_regs(8'd255, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'd0, 1'b0);
		calm = 1'b1;
		repeat (255) send_fields(OP_SAMPLE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_fields(OP_MONITOR, 16'd0, 16'd0, 16'd0, 16'd0);
		in_idle();
		drain_results();

		// Random phases, each with its own register settings. Short blocks keep
		// the averages moving; readings cluster around the set levels.
		for (int ph = 0; ph < 8; ph++) begin
			case ($urandom_range(0, 3))
				0: n = 8'd0;
				1: n = 8'd1;
				default: n = 8'($urandom_range(2, 6));
			endcase
			ots = 16'($urandom_range(500, 60000));
			otc = (ots > 62535) ? 16'hFFFF : 16'(ots + $urandom_range(0, 3000));
			ws  = (ots > 62535) ? 16'hFFFF : 16'(ots + $urandom_range(0, 3000));
			wc  = (ws > 62535) ? 16'hFFFF : 16'(ws + $urandom_range(0, 3000));
			otd = 16'($urandom_range(0, 4));
			wd  = 16'($urandom_range(0, 4));
			dis = ph[0];
			if (ph == 1) begin
				// Extreme levels: always pending, with the longest OT delay.
				ots = 16'hFFFF;
				otc = 16'd0;
				otd = 16'd65534;
				ws  = 16'hFFFF;
				wc  = 16'd0;
				wd  = 16'd0;
			end else if (ph == 2) begin
				// Levels that never move either detector.
				ots = 16'd0;
				otc = 16'hFFFF;
				ws  = 16'd0;
				wc  = 16'hFFFF;
			end
			lvl_ot   = int'(ots);
			lvl_warn = int'(ws);
			calm     = (ph % 3 == 0);
			program_regs(n, ots, otc, otd, ws, wc, wd, dis);
			pause_at = int'($urandom_range(5, 30));
			for (int k = 0; k < 40; k++) begin
				if (k == pause_at) begin
					// Hold the sender until the pipeline is empty.
					in_idle();
					drain_results();
				end
				it.opcode   = ($urandom_range(0, 9) < 4) ? OP_MONITOR : OP_SAMPLE;
				it.sample_0 = pick_reading();
				it.sample_1 = pick_reading();
				it.sample_2 = pick_reading();
				it.sample_3 = pick_reading();
				send_item(it);
			end
			in_idle();
			drain_results();
		end

		// Let the block settle for longer than its slowest item.
		repeat (120) @(posedge clk);
		if (sb.errors == 0 && sb.readouts.size() == 0) begin
			$display("end of test: clean");
		end else begin
			if (sb.readouts.size() != 0)
				$display("%0t: %0d expected results never arrived", $time,
					sb.readouts.size());
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#20_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
